// ===== rtl/page_framebuffer_draw_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the page framebuffer draw engine
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// same-cycle implication
`define PFDE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types, codes and helpers for the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

	localparam int DEF_WIDTH_PX  = 128;
	localparam int DEF_HEIGHT_PX = 64;
	localparam int PAGE_ROWS     = 8;
	localparam int STORE_DEPTH   = 1024;
	localparam int ADDR_W        = 10;
	localparam int IDX_W         = 10;
	localparam int QUEUE_DEPTH   = 4;

	// request commands
	localparam logic [2:0] CMD_PIXEL = 3'd0;
	localparam logic [2:0] CMD_HLINE = 3'd1;
	localparam logic [2:0] CMD_VLINE = 3'd2;
	localparam logic [2:0] CMD_RECT  = 3'd3;
	localparam logic [2:0] CMD_FILL  = 3'd4;
	localparam logic [2:0] CMD_READ  = 3'd5;

	// segment kinds handed to the back end
	localparam logic [2:0] SEG_NONE = 3'd0;
	localparam logic [2:0] SEG_H    = 3'd1;
	localparam logic [2:0] SEG_V    = 3'd2;
	localparam logic [2:0] SEG_FILL = 3'd3;
	localparam logic [2:0] SEG_READ = 3'd4;

	typedef struct packed {
		logic [2:0]       kind;
		logic [7:0]       x;
		logic [7:0]       y;
		logic [7:0]       cnt;
		logic             color;
		logic [IDX_W-1:0] index;
		logic             last;
	} seg_t;

	typedef struct packed {
		logic clearing;
	} bk_stat_t;

	// pixels drawn along a line of len that starts at start, clipped at the image edge
	function automatic logic [7:0] clip_len(input logic [7:0] start, input logic [7:0] across,
		input logic [7:0] len, input logic [8:0] lim_along, input logic [8:0] lim_across);
		logic [8:0] stop;
		stop = {1'b0, start} + {1'b0, len};
		if (stop > lim_along)
			stop = lim_along;
		if ({1'b0, across} >= lim_across || {1'b0, start} >= lim_along || len == 8'd0)
			return 8'd0;
		return 8'(stop - {1'b0, start});
	endfunction

endpackage

// ===== rtl/page_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome paged framebuffer: pixel, line, rectangle, fill and byte read.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser cmd, s_tdata geometry/colour/index
//  m_      | out | m_tvalid/m_tready  | m_tdata read_byte
//
//  Drawing: one pixel written per cycle by read-modify-write on the store, which
//  has separate read and write ports; each segment is taken off the queue in
//  the idle state, and the result is posted from the response state; a rectangle
//  is sent as four segments.
//  Reset: a clearing pass over all WIDTH_PX*ceil(HEIGHT_PX/8) bytes (1024 by
//  default) zeroes the store; s_tready stays low meanwhile.
//  Stalls: a 4-entry segment queue and the output register decouple both sides.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
	parameter int WIDTH_PX  = pfde_pkg::DEF_WIDTH_PX,
	parameter int HEIGHT_PX = pfde_pkg::DEF_HEIGHT_PX
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // [2:0] cmd
	input  logic [47:0] s_tdata,  // x_pos, y_pos, span_width, span_height, pixel_color,
	                              // byte_index, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [7:0] read_byte
);
	import pfde_pkg::*;

	seg_t     f_seg, q_seg;
	logic     f_push, q_full, q_valid, q_pop;
	bk_stat_t stat;

	pfde_front #(
		.WIDTH_PX  (WIDTH_PX),
		.HEIGHT_PX (HEIGHT_PX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_cmd    (s_tuser),
		.s_x      (s_tdata[7:0]),
		.s_y      (s_tdata[15:8]),
		.s_w      (s_tdata[23:16]),
		.s_h      (s_tdata[31:24]),
		.s_color  (s_tdata[32]),
		.s_index  (s_tdata[42:33]),
		.stat     (stat),
		.push     (f_push),
		.seg      (f_seg),
		.full     (q_full)
	);

	pfde_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wr_seg (f_seg),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (q_pop),
		.rd_seg (q_seg)
	);

	pfde_back #(
		.WIDTH_PX  (WIDTH_PX),
		.HEIGHT_PX (HEIGHT_PX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_seg    (q_seg),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/pfde_front.sv =====
// ----------------------------------------------------------------------------
// pfde_front
// Takes draw requests and splits them into clipped line segments, or a fill or read segment, for the queue.
// ----------------------------------------------------------------------------
module pfde_front #(
	parameter int WIDTH_PX  = pfde_pkg::DEF_WIDTH_PX,
	parameter int HEIGHT_PX = pfde_pkg::DEF_HEIGHT_PX
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [2:0]                s_cmd,
	input  logic [7:0]                s_x,
	input  logic [7:0]                s_y,
	input  logic [7:0]                s_w,
	input  logic [7:0]                s_h,
	input  logic                      s_color,
	input  logic [pfde_pkg::IDX_W-1:0] s_index,
	input  pfde_pkg::bk_stat_t        stat,
	output logic                      push,
	output pfde_pkg::seg_t            seg,
	input  logic                      full
);
	import pfde_pkg::*;

	localparam logic [8:0] LIM_X = 9'(WIDTH_PX);
	localparam logic [8:0] LIM_Y = 9'(HEIGHT_PX);

	logic             busy_q;
	logic [1:0]       seg_q;
	logic [2:0]       cmd_q;
	logic [7:0]       x_q, y_q, w_q, h_q;
	logic             color_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       x2, y2;
	logic             rect_ok;

	assign s_tready = !busy_q && !stat.clearing;
	assign push     = busy_q && !full;
	assign x2       = x_q + w_q - 8'd1;
	assign y2       = y_q + h_q - 8'd1;
	assign rect_ok  = (w_q != 8'd0) && (h_q != 8'd0);

	always_comb begin
		seg       = '0;
		seg.color = color_q;
		seg.index = idx_q;
		seg.x     = x_q;
		seg.y     = y_q;
		seg.kind  = SEG_NONE;
		seg.last  = 1'b1;
		case (cmd_q)
			CMD_PIXEL: begin
				seg.kind = SEG_H;
				seg.cnt  = clip_len(x_q, y_q, 8'd1, LIM_X, LIM_Y);
			end
			CMD_HLINE: begin
				seg.kind = SEG_H;
				seg.cnt  = clip_len(x_q, y_q, w_q, LIM_X, LIM_Y);
			end
			CMD_VLINE: begin
				seg.kind = SEG_V;
				seg.cnt  = clip_len(y_q, x_q, h_q, LIM_Y, LIM_X);
			end
			CMD_RECT: begin
				if (rect_ok) begin
					seg.last = (seg_q == 2'd3);
					case (seg_q)
						2'd0: begin
							seg.kind = SEG_H;
							seg.cnt  = clip_len(x_q, y_q, w_q, LIM_X, LIM_Y);
						end
						2'd1: begin
							seg.kind = SEG_H;
							seg.y    = y2;
							seg.cnt  = clip_len(x_q, y2, w_q, LIM_X, LIM_Y);
						end
						2'd2: begin
							seg.kind = SEG_V;
							seg.cnt  = clip_len(y_q, x_q, h_q, LIM_Y, LIM_X);
						end
						default: begin
							seg.kind = SEG_V;
							seg.x    = x2;
							seg.cnt  = clip_len(y_q, x2, h_q, LIM_Y, LIM_X);
						end
					endcase
				end
			end
			CMD_FILL: seg.kind = SEG_FILL;
			CMD_READ: seg.kind = SEG_READ;
			default:  seg.kind = SEG_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q  <= 2'd0;
		end else if (s_tvalid && s_tready) begin
			busy_q <= 1'b1;
			seg_q  <= 2'd0;
		end else if (push) begin
			if (seg.last)
				busy_q <= 1'b0;
			seg_q <= seg_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q   <= s_cmd;
			x_q     <= s_x;
			y_q     <= s_y;
			w_q     <= s_w;
			h_q     <= s_h;
			color_q <= s_color;
			idx_q   <= s_index;
		end
	end

endmodule

// ===== rtl/pfde_queue.sv =====
// ----------------------------------------------------------------------------
// pfde_queue
// Short first-word-through segment queue between front and back end.
// ----------------------------------------------------------------------------
module pfde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfde_pkg::seg_t wr_seg,
	output logic           full,
	output logic           valid,
	input  logic           pop,
	output pfde_pkg::seg_t rd_seg
);
	import pfde_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	seg_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rd_seg  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wr_seg;
	end

endmodule

// ===== rtl/pfde_back.sv =====
// ----------------------------------------------------------------------------
// pfde_back
// Owns the page store: read-modify-write line walker, fill sweep, byte read.
// ----------------------------------------------------------------------------
`include "page_framebuffer_draw_engine_macros.svh"

module pfde_back #(
	parameter int WIDTH_PX  = pfde_pkg::DEF_WIDTH_PX,
	parameter int HEIGHT_PX = pfde_pkg::DEF_HEIGHT_PX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  pfde_pkg::seg_t     q_seg,
	output pfde_pkg::bk_stat_t stat,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata
);
	import pfde_pkg::*;

	localparam int PAGES       = (HEIGHT_PX + PAGE_ROWS - 1) / PAGE_ROWS;
	localparam int IMAGE_BYTES = WIDTH_PX * PAGES;
	localparam int MEM_AW      = $clog2(IMAGE_BYTES);
	localparam logic [MEM_AW-1:0] FILL_LAST = MEM_AW'(IMAGE_BYTES - 1);
	localparam logic [IDX_W:0]    IMG_LIM   = (IDX_W + 1)'(IMAGE_BYTES);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_HRUN = 3'd2;
	localparam logic [2:0] ST_VRUN = 3'd3;
	localparam logic [2:0] ST_FILL = 3'd4;
	localparam logic [2:0] ST_RD   = 3'd5;
	localparam logic [2:0] ST_RESP = 3'd6;

	logic [7:0]        mem [IMAGE_BYTES];
	logic [7:0]        rdata_q;

	logic [2:0]        st_q;
	logic [MEM_AW-1:0] fill_q;
	logic [7:0]        x_q, y_q, cnt_q;
	logic              color_q, last_q, rd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	logic              vld_s1;
	logic [MEM_AW-1:0] addr_s1;
	logic [7:0]        mask_s1;
	logic              color_s1;

	logic              fwd_vld_q;
	logic [MEM_AW-1:0] fwd_addr_q;
	logic [7:0]        fwd_data_q;

	logic [ADDR_W-1:0] pix_addr;
	logic [MEM_AW-1:0] raddr, waddr;
	logic              we;
	logic [7:0]        wdata, base, rmw_data, result;
	logic              running, resp_go;
	logic [2:0]        idle_next;

	assign stat.clearing = (st_q == ST_CLR);
	assign m_tvalid      = m_tvalid_q;
	assign m_tdata       = m_tdata_q;
	assign q_pop         = (st_q == ST_IDLE) && q_valid;
	assign running       = (st_q == ST_HRUN) || (st_q == ST_VRUN);
	assign resp_go       = !m_tvalid_q || m_tready;

	assign pix_addr = ADDR_W'(x_q) + ADDR_W'(y_q >> 3) * ADDR_W'(WIDTH_PX);
	assign raddr    = running ? pix_addr[MEM_AW-1:0] : idx_q[MEM_AW-1:0];

	// forward the previous write when the pixel lands in the same byte
	assign base     = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_data_q : rdata_q;
	assign rmw_data = color_s1 ? (base | mask_s1) : (base & ~mask_s1);
	assign result   = (rd_q && {1'b0, idx_q} < IMG_LIM) ? rdata_q : 8'h00;

	always_comb begin
		if (st_q == ST_CLR || st_q == ST_FILL) begin
			we    = 1'b1;
			waddr = fill_q;
			wdata = (st_q == ST_FILL && color_q) ? 8'hFF : 8'h00;
		end else begin
			we    = vld_s1;
			waddr = addr_s1;
			wdata = rmw_data;
		end
	end

	always_comb begin
		idle_next = q_seg.last ? ST_RESP : ST_IDLE;
		case (q_seg.kind)
			SEG_H:    if (q_seg.cnt != 8'd0) idle_next = ST_HRUN;
			SEG_V:    if (q_seg.cnt != 8'd0) idle_next = ST_VRUN;
			SEG_FILL: idle_next = ST_FILL;
			SEG_READ: idle_next = ST_RD;
			default:  idle_next = q_seg.last ? ST_RESP : ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLR;
			fill_q     <= '0;
			vld_s1     <= 1'b0;
			fwd_vld_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			vld_s1    <= running;
			fwd_vld_q <= vld_s1;
			if (st_q == ST_RESP && resp_go)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					fill_q <= fill_q + MEM_AW'(1);
					if (fill_q == FILL_LAST)
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					fill_q <= '0;
					if (q_pop)
						st_q <= idle_next;
				end
				ST_HRUN, ST_VRUN: begin
					if (cnt_q == 8'd1)
						st_q <= last_q ? ST_RESP : ST_IDLE;
				end
				ST_FILL: begin
					fill_q <= fill_q + MEM_AW'(1);
					if (fill_q == FILL_LAST)
						st_q <= ST_RESP;
				end
				ST_RD:   st_q <= ST_RESP;
				ST_RESP: begin
					if (resp_go)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			x_q     <= q_seg.x;
			y_q     <= q_seg.y;
			cnt_q   <= q_seg.cnt;
			color_q <= q_seg.color;
			last_q  <= q_seg.last;
			idx_q   <= q_seg.index;
			rd_q    <= (q_seg.kind == SEG_READ);
		end else if (st_q == ST_HRUN) begin
			x_q   <= x_q + 8'd1;
			cnt_q <= cnt_q - 8'd1;
		end else if (st_q == ST_VRUN) begin
			y_q   <= y_q + 8'd1;
			cnt_q <= cnt_q - 8'd1;
		end
		if (running) begin
			addr_s1  <= pix_addr[MEM_AW-1:0];
			mask_s1  <= 8'd1 << y_q[2:0];
			color_s1 <= color_q;
		end
		if (vld_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= rmw_data;
		end
		if (st_q == ST_RESP && resp_go)
			m_tdata_q <= result;
	end

	`PFDE_ASSERT_IMPL(a_rmw_no_sweep, vld_s1, (st_q != ST_FILL && st_q != ST_CLR), "pixel write clashes with sweep")
	`PFDE_ASSERT_IMPL(a_pop_idle, q_pop, (st_q == ST_IDLE), "segment taken outside idle")
	`PFDE_ASSERT_NEXT(a_resp_wait, (st_q == ST_RESP && m_tvalid && !m_tready), (st_q == ST_RESP), "result dropped while output full")

endmodule
